// ----- rtl/core/palette_tile_mipmap_reducer_macros.svh -----
// Assertion macros shared by the checker of the palette tile reducer.
// Needs signals clk and arst_n in the scope where the macros are used.
`ifndef PALETTE_TILE_MIPMAP_REDUCER_MACROS_SVH
`define PALETTE_TILE_MIPMAP_REDUCER_MACROS_SVH

// same-cycle implication
`define PTM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptm assertion failed");

// next-cycle implication
`define PTM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptm assertion failed");

`endif

// ----- rtl/core/ptm_pkg.sv -----
// Package of the palette tile reducer: opcodes, register indexes, widths,
// controller states and the command/status structs. No dependencies.
package ptm_pkg;

	typedef enum logic [1:0] {
		OP_PIXEL    = 2'd0,
		OP_LOAD_SRC = 2'd1,
		OP_LOAD_DST = 2'd2,
		OP_LOAD_LUT = 2'd3
	} op_t;

	localparam logic REG_LEVEL     = 1'b0;
	localparam logic REG_USE_TABLE = 1'b1;

	localparam int SUM_W        = 14;
	localparam int CNT_W        = 7;
	localparam int POS_W        = 6;
	localparam int LUT_AW       = 16;
	localparam int LUT_ENTRIES  = 65536;
	localparam int SEARCH_LIMIT = 255;

	localparam logic [7:0] TRANSPARENT_INDEX = 8'hFF;
	localparam logic [9:0] MAX_DISTANCE      = 10'd768;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PIX,
		ST_CHECK,
		ST_DIV_LOAD,
		ST_DIV_WAIT,
		ST_MAP,
		ST_TBL_WAIT,
		ST_SRCH,
		ST_SRCH_FLUSH,
		ST_SRCH_TAKE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic accum;
		logic div_start;
		logic tbl_read;
		logic tbl_take;
		logic srch_start;
		logic srch_step;
		logic srch_take;
		logic transp;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tile_end;
		logic opaque_major;
		logic div_done;
		logic ch_last;
		logic srch_last;
		logic use_table;
		logic out_free;
	} ctrl_stat_t;

endpackage

// ----- rtl/core/ptm_if.sv -----
// Request channel interfaces of the palette tile reducer.
// Depends on nothing; payload widths are fixed.
interface ptm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  color_index;

	modport source (output valid, op, address, red, green, blue, color_index, input ready);
	modport sink   (input valid, op, address, red, green, blue, color_index, output ready);
endinterface

interface ptm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_index;
	logic       transparent;

	modport source (output valid, out_index, transparent, input ready);
	modport sink   (input valid, out_index, transparent, output ready);
endinterface

// ----- rtl/core/ptm_div.sv -----
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on nothing; used by ptm_datapath for the rounded channel means.
module ptm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [7:0]  quotient
);
	logic        busy_q;
	logic        done_q;
	logic [2:0]  step_q;
	logic [15:0] rem_q;
	logic [7:0]  quo_q;
	logic [15:0] shifted;
	logic        ge;

	assign shifted  = {8'd0, divisor} << step_q;
	assign ge       = rem_q >= shifted;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd7;
			end else if (busy_q) begin
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q && ge) begin
			rem_q         <= rem_q - shifted;
			quo_q[step_q] <= 1'b1;
		end
	end
endmodule

// ----- rtl/core/ptm_datapath.sv -----
// Datapath of the palette tile reducer: palettes, lookup table, tile sums,
// divider, nearest-entry search and output register. Uses ptm_pkg, ptm_div.
module ptm_datapath #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_LEVEL       = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  logic [1:0]             op,
	input  logic [15:0]            address,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic [7:0]             color_index,
	input  logic                   cfg_wen,
	input  logic                   cfg_index,
	input  logic [1:0]             cfg_wdata,
	input  ptm_pkg::ctrl_cmd_t     cmd,
	output ptm_pkg::ctrl_stat_t    stat,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [7:0]             out_index,
	output logic                   transparent
);
	import ptm_pkg::*;

	localparam int PW       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int SEARCH_N = (PALETTE_ENTRIES < SEARCH_LIMIT) ? PALETTE_ENTRIES : SEARCH_LIMIT;
	localparam logic [1:0] CH_RED  = 2'd0;
	localparam logic [1:0] CH_GRN  = 2'd1;
	localparam logic [1:0] CH_BLU  = 2'd2;

	logic [23:0] src_pal [PALETTE_ENTRIES];
	logic [23:0] dst_pal [PALETTE_ENTRIES];
	logic [7:0]  lut     [LUT_ENTRIES];

	logic [1:0]  level_q;
	logic        use_table_q;

	logic [23:0] src_rd_s1;
	logic        px_opaque_s1;
	logic        px_inrange_s1;
	logic [23:0] dst_rd_s1;
	logic [7:0]  lut_rd_s1;

	logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] pos_q;

	logic [1:0]  ch_q;
	logic [7:0]  mean_r_q, mean_g_q, mean_b_q;
	logic [SUM_W-1:0] div_sum;
	logic [15:0] div_dividend;
	logic        div_done;
	logic [7:0]  div_quo;

	logic [PW-1:0] srch_i_q;
	logic [PW-1:0] srch_idx_s1;
	logic          srch_v_s1;
	logic [7:0]    best_q;
	logic [9:0]    best_dist_q;
	logic [9:0]    cand_dist;

	logic [7:0]  res_idx_q;
	logic        res_transp_q;
	logic        out_valid_q;
	logic [7:0]  out_idx_q;
	logic        out_transp_q;

	logic [1:0]  lv_eff;
	logic [6:0]  tile_size;
	logic [6:0]  pos_next;
	logic [23:0] px_color;
	logic        src_wr_ok, dst_wr_ok;
	logic [LUT_AW-1:0] lut_addr;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			use_table_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_LEVEL:     level_q     <= cfg_wdata;
				REG_USE_TABLE: use_table_q <= cfg_wdata[0];
				default:       ;
			endcase
		end
	end

	// Memories
	assign src_wr_ok = {1'b0, address} < 17'(PALETTE_ENTRIES);
	assign dst_wr_ok = src_wr_ok;
	assign lut_addr  = {mean_b_q[7:3], mean_g_q[7:2], mean_r_q[7:3]};

	always_ff @(posedge clk) begin
		if (in_accept && op == OP_LOAD_SRC && src_wr_ok)
			src_pal[address[PW-1:0]] <= {red, green, blue};
		if (in_accept && op == OP_PIXEL)
			src_rd_s1 <= src_pal[color_index[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_accept && op == OP_LOAD_DST && dst_wr_ok)
			dst_pal[address[PW-1:0]] <= {red, green, blue};
		dst_rd_s1 <= dst_pal[srch_i_q];
	end

	always_ff @(posedge clk) begin
		if (in_accept && op == OP_LOAD_LUT)
			lut[address] <= color_index;
		if (cmd.tbl_read)
			lut_rd_s1 <= lut[lut_addr];
	end

	always_ff @(posedge clk) begin
		if (in_accept && op == OP_PIXEL) begin
			px_opaque_s1  <= color_index != TRANSPARENT_INDEX;
			px_inrange_s1 <= {1'b0, color_index} < 9'(PALETTE_ENTRIES);
		end
	end

	// Tile accumulation
	assign lv_eff    = (int'(level_q) > MAX_LEVEL) ? 2'(MAX_LEVEL) : level_q;
	assign tile_size = 7'd1 << {lv_eff, 1'b0};
	assign pos_next  = {1'b0, pos_q} + 7'd1;
	assign px_color  = px_inrange_s1 ? src_rd_s1 : 24'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else if (cmd.finish) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else if (cmd.accum) begin
			if (px_opaque_s1) begin
				sum_r_q <= sum_r_q + SUM_W'(px_color[23:16]);
				sum_g_q <= sum_g_q + SUM_W'(px_color[15:8]);
				sum_b_q <= sum_b_q + SUM_W'(px_color[7:0]);
				cnt_q   <= cnt_q + CNT_W'(1);
			end
			if (pos_next < tile_size)
				pos_q <= pos_q + POS_W'(1);
		end
	end

	// Rounded means: floor((2*sum + n) / (2*n)), one channel after another
	always_comb begin
		case (ch_q)
			CH_RED:  div_sum = sum_r_q;
			CH_GRN:  div_sum = sum_g_q;
			default: div_sum = sum_b_q;
		endcase
	end
	assign div_dividend = {1'b0, div_sum, 1'b0} + 16'(cnt_q);

	ptm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  ({cnt_q, 1'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ch_q <= CH_RED;
		else if (cmd.finish)
			ch_q <= CH_RED;
		else if (div_done)
			ch_q <= ch_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (ch_q)
				CH_RED:  mean_r_q <= div_quo;
				CH_GRN:  mean_g_q <= div_quo;
				default: mean_b_q <= div_quo;
			endcase
		end
	end

	// Nearest destination entry, one entry per cycle
	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign cand_dist = 10'(abs_diff(dst_rd_s1[23:16], mean_r_q))
		+ 10'(abs_diff(dst_rd_s1[15:8], mean_g_q))
		+ 10'(abs_diff(dst_rd_s1[7:0], mean_b_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_v_s1 <= 1'b0;
			srch_i_q  <= '0;
		end else begin
			srch_v_s1 <= cmd.srch_step;
			if (cmd.srch_start)
				srch_i_q <= '0;
			else if (cmd.srch_step)
				srch_i_q <= srch_i_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		srch_idx_s1 <= srch_i_q;
		if (cmd.srch_start) begin
			best_q      <= '0;
			best_dist_q <= MAX_DISTANCE;
		end else if (srch_v_s1 && cand_dist < best_dist_q) begin
			best_q      <= 8'(srch_idx_s1);
			best_dist_q <= cand_dist;
		end
	end

	// Result and output register
	always_ff @(posedge clk) begin
		if (cmd.transp) begin
			res_idx_q    <= TRANSPARENT_INDEX;
			res_transp_q <= 1'b1;
		end else if (cmd.tbl_take) begin
			res_idx_q    <= lut_rd_s1;
			res_transp_q <= 1'b0;
		end else if (cmd.srch_take) begin
			res_idx_q    <= best_q;
			res_transp_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_idx_q    <= res_idx_q;
			out_transp_q <= res_transp_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_index   = out_idx_q;
	assign transparent = out_transp_q;

	always_comb begin
		stat.tile_end     = pos_next >= tile_size;
		stat.opaque_major = cnt_q > (tile_size >> 1);
		stat.div_done     = div_done;
		stat.ch_last      = ch_q == CH_BLU;
		stat.srch_last    = srch_i_q == PW'(SEARCH_N - 1);
		stat.use_table    = use_table_q;
		stat.out_free     = !out_valid_q || out_ready;
	end
endmodule

// ----- rtl/core/ptm_ctrl.sv -----
// Controller state machine of the palette tile reducer.
// Uses ptm_pkg; drives ptm_datapath through ctrl_cmd_t.
module ptm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	input  ptm_pkg::ctrl_stat_t stat,
	output ptm_pkg::ctrl_cmd_t  cmd
);
	import ptm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (in_valid && in_op == OP_PIXEL) state_d = ST_PIX;
			ST_PIX:        state_d = stat.tile_end ? ST_CHECK : ST_IDLE;
			ST_CHECK:      state_d = stat.opaque_major ? ST_DIV_LOAD : ST_RESULT;
			ST_DIV_LOAD:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (stat.div_done)
					state_d = stat.ch_last ? ST_MAP : ST_DIV_LOAD;
			end
			ST_MAP:        state_d = stat.use_table ? ST_TBL_WAIT : ST_SRCH;
			ST_TBL_WAIT:   state_d = ST_RESULT;
			ST_SRCH:       if (stat.srch_last) state_d = ST_SRCH_FLUSH;
			ST_SRCH_FLUSH: state_d = ST_SRCH_TAKE;
			ST_SRCH_TAKE:  state_d = ST_RESULT;
			ST_RESULT:     if (stat.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE:      in_ready = 1'b1;
			ST_PIX:       cmd.accum = 1'b1;
			ST_CHECK:     cmd.transp = !stat.opaque_major;
			ST_DIV_LOAD:  cmd.div_start = 1'b1;
			ST_MAP: begin
				cmd.tbl_read   = stat.use_table;
				cmd.srch_start = !stat.use_table;
			end
			ST_TBL_WAIT:  cmd.tbl_take = 1'b1;
			ST_SRCH:      cmd.srch_step = 1'b1;
			ST_SRCH_TAKE: cmd.srch_take = 1'b1;
			ST_RESULT:    cmd.finish = stat.out_free;
			default:      ;
		endcase
	end
endmodule

// ----- rtl/core/palette_tile_mipmap_reducer.sv -----
// Top level of the palette tile reducer: controller plus datapath.
// Uses ptm_pkg, ptm_if, ptm_ctrl, ptm_datapath.
// Usage: data_in carries requests; op selects a pixel or a load of the source
//  palette, destination palette or 5-6-5 lookup table. Pixels of one tile
//  (side 2^level) arrive in tile order. data_out carries one request per
//  finished tile: out_index and transparent. cfg_wen/cfg_index/cfg_wdata write
//  level (index 0), use_table (index 1); user must write only while idle, unchecked.
// Timing: one request at a time. A load is accepted in idle; a pixel inside a
//  tile is accepted, then accumulated. The last pixel of a tile adds a check,
//  then the three divisions in the shared one-bit-per-cycle divider, then a
//  lookup table read, or the search of up to 255 destination entries (one per
//  cycle) followed by a flush and a take of the nearest entry. A transparent
//  tile goes from the check straight to the result state.
// Reset clears sums, tile position, registers and the output valid flag; the
//  palettes and table hold nothing defined until loaded.
// Stall: the result sits in an output register; data_in keeps accepting
//  requests while it waits. A following tile result waits in its final
//  state until the register is free.
module palette_tile_mipmap_reducer #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_LEVEL       = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	ptm_in_if.sink           data_in,
	ptm_out_if.source        data_out,
	input  logic             cfg_wen,
	input  logic             cfg_index,
	input  logic [1:0]       cfg_wdata
);
	import ptm_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	logic       in_ready;
	logic       in_accept;

	assign data_in.ready = in_ready;
	assign in_accept     = data_in.valid && in_ready;

	ptm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (data_in.valid),
		.in_op    (data_in.op),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptm_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.MAX_LEVEL       (MAX_LEVEL)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.op          (data_in.op),
		.address     (data_in.address),
		.red         (data_in.red),
		.green       (data_in.green),
		.blue        (data_in.blue),
		.color_index (data_in.color_index),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (data_out.ready),
		.out_valid   (data_out.valid),
		.out_index   (data_out.out_index),
		.transparent (data_out.transparent)
	);
endmodule

// ----- rtl/core/ptm_checker.sv -----
// Port-level checker of the palette tile reducer, bound to the top level.
// Uses ptm_pkg and palette_tile_mipmap_reducer_macros.svh.
`include "palette_tile_mipmap_reducer_macros.svh"

module ptm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_index,
	input logic       transparent
);
	import ptm_pkg::*;

	// after a pixel request is accepted, ready drops while the block works on it
	`PTM_ASSERT_NEXT(a_pix_busy, in_valid && in_ready && in_op == OP_PIXEL, !in_ready)
	// loads complete in the accept cycle
	`PTM_ASSERT_NEXT(a_load_ready, in_valid && in_ready && in_op != OP_PIXEL, in_ready)
	// transparent tiles always report the transparent index
	`PTM_ASSERT_NOW(a_transp_idx, out_valid && transparent, out_index == TRANSPARENT_INDEX)
	// a result is held until taken
	`PTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_index))
endmodule

bind palette_tile_mipmap_reducer ptm_checker u_ptm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (data_in.valid),
	.in_ready    (data_in.ready),
	.in_op       (data_in.op),
	.out_valid   (data_out.valid),
	.out_ready   (data_out.ready),
	.out_index   (data_out.out_index),
	.transparent (data_out.transparent)
);
